// File: hw/rtl/rlavg_pkg.sv
// Shared package for the region luminance average unit.
// Holds field widths, register indexes, reset values and the luminance helper.
// No dependencies.
`default_nettype none

package rlavg_pkg;

  // Default sizing limits, handed to the top level parameters.
  localparam int MAX_REGION_DEFAULT = 64;
  localparam int MAX_FRAME_DEFAULT  = 4096;

  // Fixed field widths.
  localparam int COORD_W      = 12;
  localparam int PIX_W        = 8;
  localparam int AVG_W        = 8;
  localparam int FRAME_CFG_W  = 13;
  localparam int REGION_CFG_W = 7;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT = 2'd3;

  // Register values after reset.
  localparam logic [FRAME_CFG_W-1:0]  FRAME_WIDTH_RST   = 13'd640;
  localparam logic [FRAME_CFG_W-1:0]  FRAME_HEIGHT_RST  = 13'd480;
  localparam logic [REGION_CFG_W-1:0] REGION_WIDTH_RST  = 7'd8;
  localparam logic [REGION_CFG_W-1:0] REGION_HEIGHT_RST = 7'd8;

  // Divide by three of a value below 768: multiply by 683 and drop 11 bits.
  localparam int RGB_SUM_W  = 10;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_PROD_W = 20;

  // Entries in the queue between the accumulator and the divider.
  localparam int QUEUE_DEPTH = 4;

  // Luminance of one pixel: floor((r + g + b) / 3).
  function automatic logic [PIX_W-1:0] luma3(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
    logic [RGB_SUM_W-1:0]   s;
    logic [DIV3_PROD_W-1:0] p;
    s = RGB_SUM_W'(r) + RGB_SUM_W'(g) + RGB_SUM_W'(b);
    p = DIV3_PROD_W'(s) * DIV3_PROD_W'(DIV3_MUL);
    return p[DIV3_SHIFT +: PIX_W];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rlavg_front.sv
// Front end of the region luminance average unit: configuration registers,
// region position counters and the luminance accumulator. Uses rlavg_pkg.
`default_nettype none

module rlavg_front import rlavg_pkg::*; #(
  parameter int MAX_REGION = MAX_REGION_DEFAULT,
  parameter int MAX_FRAME  = MAX_FRAME_DEFAULT,
  localparam int CNT_W = $clog2(MAX_REGION * MAX_REGION + 1),
  localparam int SUM_W = CNT_W + AVG_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Pixel beats
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_W-1:0]    start_x,
  input  wire logic [COORD_W-1:0]    start_y,
  input  wire logic [PIX_W-1:0]      red,
  input  wire logic [PIX_W-1:0]      green,
  input  wire logic [PIX_W-1:0]      blue,
  // Finished region totals towards the queue
  input  wire logic                  q_full,
  output logic                       q_push,
  output logic [SUM_W-1:0]           q_sum,
  output logic [CNT_W-1:0]           q_count
);

  localparam int POS_W  = (MAX_REGION > 1) ? $clog2(MAX_REGION) : 1;
  localparam int RS_W   = ($clog2(MAX_REGION + 1) > REGION_CFG_W) ?
                          $clog2(MAX_REGION + 1) : REGION_CFG_W;
  localparam int FS_W   = ($clog2(MAX_FRAME + 1) > FRAME_CFG_W + 1) ?
                          $clog2(MAX_FRAME + 1) : FRAME_CFG_W + 1;

  logic [FRAME_CFG_W-1:0]  frame_width;
  logic [FRAME_CFG_W-1:0]  frame_height;
  logic [REGION_CFG_W-1:0] region_width;
  logic [REGION_CFG_W-1:0] region_height;

  logic [POS_W-1:0] column_count;
  logic [POS_W-1:0] row_count;
  logic [SUM_W-1:0] luminance_sum;
  logic [CNT_W-1:0] sample_count;

  logic [RS_W-1:0]  rw_ext, rh_ext, rw_eff, rh_eff;
  logic [RS_W-1:0]  col_inc, row_inc;
  logic [FS_W-1:0]  fw_ext, fh_ext, fw_eff, fh_eff;
  logic [FS_W-1:0]  pos_x, pos_y;
  logic             in_frame, col_wrap, row_wrap, accept;
  logic [PIX_W-1:0] luma;
  logic [SUM_W-1:0] luminance_sum_next;
  logic [CNT_W-1:0] sample_count_next;

  // Configuration register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
      region_width  <= REGION_WIDTH_RST;
      region_height <= REGION_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[FRAME_CFG_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[FRAME_CFG_W-1:0];
        REG_REGION_WIDTH:  region_width  <= cfg_data[REGION_CFG_W-1:0];
        REG_REGION_HEIGHT: region_height <= cfg_data[REGION_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: region sizes clamp to one and the maximum, frame sizes
  // clamp to the maximum.
  always_comb begin
    rw_ext = RS_W'(region_width);
    rh_ext = RS_W'(region_height);
    fw_ext = FS_W'(frame_width);
    fh_ext = FS_W'(frame_height);
    if (rw_ext == '0)                     rw_eff = RS_W'(1);
    else if (rw_ext > RS_W'(MAX_REGION))  rw_eff = RS_W'(MAX_REGION);
    else                                  rw_eff = rw_ext;
    if (rh_ext == '0)                     rh_eff = RS_W'(1);
    else if (rh_ext > RS_W'(MAX_REGION))  rh_eff = RS_W'(MAX_REGION);
    else                                  rh_eff = rh_ext;
    fw_eff = (fw_ext > FS_W'(MAX_FRAME)) ? FS_W'(MAX_FRAME) : fw_ext;
    fh_eff = (fh_ext > FS_W'(MAX_FRAME)) ? FS_W'(MAX_FRAME) : fh_ext;
  end

  // Classify the current pixel and find the end of a row and of the region.
  always_comb begin
    pos_x    = FS_W'(start_x) + FS_W'(column_count);
    pos_y    = FS_W'(start_y) + FS_W'(row_count);
    in_frame = (pos_x < fw_eff) && (pos_y < fh_eff);
    col_inc  = RS_W'(column_count) + RS_W'(1);
    row_inc  = RS_W'(row_count) + RS_W'(1);
    col_wrap = !(col_inc < rw_eff);
    row_wrap = !(row_inc < rh_eff);
    luma     = luma3(red, green, blue);
    luminance_sum_next = luminance_sum;
    sample_count_next  = sample_count;
    if (in_frame) begin
      luminance_sum_next = luminance_sum + SUM_W'(luma);
      sample_count_next  = sample_count + CNT_W'(1);
    end
  end

  // Hold off pixels while the queue cannot take another region.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign q_push  = accept && col_wrap && row_wrap;
  assign q_sum   = luminance_sum_next;
  assign q_count = sample_count_next;

  // Position counters and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      luminance_sum <= '0;
      sample_count  <= '0;
    end else if (accept) begin
      if (!col_wrap) begin
        column_count  <= col_inc[POS_W-1:0];
        luminance_sum <= luminance_sum_next;
        sample_count  <= sample_count_next;
      end else if (!row_wrap) begin
        column_count  <= '0;
        row_count     <= row_inc[POS_W-1:0];
        luminance_sum <= luminance_sum_next;
        sample_count  <= sample_count_next;
      end else begin
        column_count  <= '0;
        row_count     <= '0;
        luminance_sum <= '0;
        sample_count  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rlavg_queue.sv
// Small register queue that carries finished region totals from the
// accumulator to the divider. Uses rlavg_pkg for its depth.
`default_nettype none

module rlavg_queue import rlavg_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  nonempty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [OCC_W-1:0] fill;
  logic             do_push, do_pop;

  assign full     = (fill == OCC_W'(QUEUE_DEPTH));
  assign nonempty = (fill != '0);
  assign rdata    = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + OCC_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - OCC_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rlavg_divider.sv
// Back end of the region luminance average unit: a restoring divider that
// finds one quotient bit a cycle, and the output register. Uses rlavg_pkg.
`default_nettype none

module rlavg_divider import rlavg_pkg::*; #(
  parameter int MAX_REGION = MAX_REGION_DEFAULT,
  localparam int CNT_W = $clog2(MAX_REGION * MAX_REGION + 1),
  localparam int SUM_W = CNT_W + AVG_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Region totals from the queue
  input  wire logic             q_nonempty,
  input  wire logic [SUM_W-1:0] q_sum,
  input  wire logic [CNT_W-1:0] q_count,
  output logic                  q_pop,
  // Result beats
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [AVG_W-1:0]      average,
  output logic                  empty_res
);

  localparam int STEP_W = $clog2(AVG_W);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  remainder;
  logic [CNT_W-1:0]  divisor;
  logic [AVG_W-1:0]  quotient;
  logic [SUM_W-1:0]  trial;
  logic              fits, out_free;

  // The quotient is below 256, so the divisor shifted by up to seven
  // places always fits the remainder width.
  assign trial    = SUM_W'(divisor) << step;
  assign fits     = (remainder >= trial);
  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == S_IDLE) && q_nonempty;

  // Division sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_nonempty) begin
            state <= S_RUN;
            step  <= STEP_W'(AVG_W - 1);
          end
        end
        S_RUN: begin
          if (step == '0) begin
            state <= S_DONE;
          end else begin
            step <= step - STEP_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider datapath: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_nonempty) begin
      remainder <= q_sum;
      divisor   <= q_count;
      quotient  <= '0;
    end else if (state == S_RUN && fits) begin
      remainder      <= remainder - trial;
      quotient[step] <= 1'b1;
    end
  end

  // Output register; an empty region reports zero with the empty flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      empty_res <= (divisor == '0);
      average   <= (divisor == '0) ? '0 : quotient;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/region_luminance_average_unit.sv
// Region luminance average unit. Pixels are taken one a cycle; the front end
// stalls only while its region queue is full. A region total passes through the
// queue and the divider, one quotient bit a cycle, to the output register. The
// divider takes no new region before then; the four-entry queue absorbs bursts.
// Reset restores the register defaults and clears counters, sums and queue.
`default_nettype none

module region_luminance_average_unit import rlavg_pkg::*; #(
  parameter int MAX_REGION = MAX_REGION_DEFAULT,
  parameter int MAX_FRAME  = MAX_FRAME_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Pixel channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_W-1:0]    start_x,
  input  wire logic [COORD_W-1:0]    start_y,
  input  wire logic [PIX_W-1:0]      red,
  input  wire logic [PIX_W-1:0]      green,
  input  wire logic [PIX_W-1:0]      blue,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [AVG_W-1:0]           average,
  output logic                       empty_res
);

  localparam int CNT_W = $clog2(MAX_REGION * MAX_REGION + 1);
  localparam int SUM_W = CNT_W + AVG_W;

  logic             q_push, q_pop, q_full, q_nonempty;
  logic [SUM_W-1:0] push_sum, pop_sum;
  logic [CNT_W-1:0] push_count, pop_count;

  // Accumulator front end.
  rlavg_front #(
    .MAX_REGION (MAX_REGION),
    .MAX_FRAME  (MAX_FRAME)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_x   (start_x),
    .start_y   (start_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_sum     (push_sum),
    .q_count   (push_count)
  );

  // Queue of finished region totals.
  rlavg_queue #(
    .WIDTH (SUM_W + CNT_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    ({push_sum, push_count}),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rdata    ({pop_sum, pop_count})
  );

  // Divider back end.
  rlavg_divider #(
    .MAX_REGION (MAX_REGION)
  ) u_divider (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_sum      (pop_sum),
    .q_count    (pop_count),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .average    (average),
    .empty_res  (empty_res)
  );

endmodule

`default_nettype wire

// File: tb/region_luminance_average_unit_test.sv
// Self-checking testbench for the region luminance average unit.
// Predicts every region average in SystemVerilog and checks each result beat.
// Depends on rlavg_pkg and region_luminance_average_unit.
`timescale 1ns / 1ps

module region_luminance_average_unit_test;
  import rlavg_pkg::*;

  localparam int RANDOM_PIXELS  = 600;
  localparam int SETTLE_CYCLES  = 24;
  localparam int TAIL_CYCLES    = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic             empty_res;
  } region_result_t;

  // Block inputs, all known from time zero.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic [COORD_W-1:0]    start_x = '0;
  logic [COORD_W-1:0]    start_y = '0;
  logic [PIX_W-1:0]      red = '0;
  logic [PIX_W-1:0]      green = '0;
  logic [PIX_W-1:0]      blue = '0;
  logic                  out_stall = 1'b0;

  // Block outputs.
  logic                  in_stall;
  logic                  out_valid;
  logic [AVG_W-1:0]      average;
  logic                  empty_res;

  // Shadow copy of the registers and the accumulation state.
  logic [FRAME_CFG_W-1:0]  frame_w_reg = FRAME_WIDTH_RST;
  logic [FRAME_CFG_W-1:0]  frame_h_reg = FRAME_HEIGHT_RST;
  logic [REGION_CFG_W-1:0] region_w_reg = REGION_WIDTH_RST;
  logic [REGION_CFG_W-1:0] region_h_reg = REGION_HEIGHT_RST;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  int unsigned luma_total = 0;
  int unsigned in_frame_count = 0;

  region_result_t averages_due[$];

  int unsigned fail_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  int unsigned hold_req_id = 0;

  region_luminance_average_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_x   (start_x),
    .start_y   (start_y),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .average   (average),
    .empty_res (empty_res)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("error: %s", what);
    end
  endtask

  function automatic int unsigned bounded(input int unsigned v, input int unsigned lo,
                                          input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Folds one accepted pixel into the shadow state; queues a result when the
  // region closes and reports whether it did.
  function automatic bit fold_pixel(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                    input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                    input logic [PIX_W-1:0] b);
    int unsigned    cols;
    int unsigned    rows;
    int unsigned    fcols;
    int unsigned    frows;
    region_result_t res;
    cols  = bounded(region_w_reg, 1, MAX_REGION_DEFAULT);
    rows  = bounded(region_h_reg, 1, MAX_REGION_DEFAULT);
    fcols = bounded(frame_w_reg, 0, MAX_FRAME_DEFAULT);
    frows = bounded(frame_h_reg, 0, MAX_FRAME_DEFAULT);
    if (32'(sx) + col_pos < fcols && 32'(sy) + row_pos < frows) begin
      luma_total += (32'(r) + 32'(g) + 32'(b)) / 3;
      in_frame_count++;
    end
    if (col_pos + 1 < cols) begin
      col_pos++;
      return 1'b0;
    end
    col_pos = 0;
    if (row_pos + 1 < rows) begin
      row_pos++;
      return 1'b0;
    end
    // An empty region reports zero with the empty flag set.
    res.empty_res = (in_frame_count == 0);
    res.average   = (in_frame_count == 0) ? '0 : AVG_W'(luma_total / in_frame_count);
    averages_due.push_back(res);
    row_pos = 0;
    luma_total = 0;
    in_frame_count = 0;
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] random_channel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Origin near the frame border, at zero, or anywhere.
  function automatic logic [COORD_W-1:0] pick_origin(input logic [CFG_DATA_W-1:0] frame_cfg,
                                                     input int unsigned span);
    int border;
    case ($urandom_range(0, 3))
      0: return '0;
      1, 2: begin
        border = int'(bounded(frame_cfg, 0, MAX_FRAME_DEFAULT)) - int'($urandom_range(0, span));
        if (border < 0) border = 0;
        if (border > 4095) border = 4095;
        return COORD_W'(border);
      end
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_frame_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'($urandom);
      2: return '1;
      default: return CFG_DATA_W'($urandom_range(1, MAX_FRAME_DEFAULT));
    endcase
  endfunction

  // Mostly tiny regions so results come often; now and then a large one.
  function automatic logic [CFG_DATA_W-1:0] pick_region_size();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return CFG_DATA_W'($urandom_range(0, 4));
    if (pick < 18) return CFG_DATA_W'($urandom_range(5, 16));
    if (pick == 18) return CFG_DATA_W'($urandom_range(MAX_REGION_DEFAULT, 127));
    return CFG_DATA_W'($urandom);
  endfunction

  // Offers one pixel beat, optionally after an idle burst, and waits for it.
  task automatic send_pixel(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                            input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                            input logic [PIX_W-1:0] b, output bit closed);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start_x  <= sx;
    start_y  <= sy;
    red      <= r;
    green    <= g;
    blue     <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    closed = fold_pixel(sx, sy, r, g, b);
    pixels_sent++;
  endtask

  // Sends pixels until the region closes; jitter scrambles the origin now and then.
  task automatic send_region(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input bit jitter);
    bit                 closed;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    closed = 1'b0;
    while (!closed) begin
      px = (jitter && $urandom_range(0, 3) == 0) ? COORD_W'($urandom) : sx;
      py = (jitter && $urandom_range(0, 3) == 0) ? COORD_W'($urandom) : sy;
      send_pixel(px, py, random_channel(), random_channel(), random_channel(), closed);
    end
  endtask

  task automatic send_partial(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                              input int unsigned count);
    bit closed;
    repeat (count) send_pixel(sx, sy, random_channel(), random_channel(), random_channel(),
                              closed);
  endtask

  // Stops offering pixels and waits until every result is in and the pipe is quiet.
  task automatic wait_until_settled();
    in_valid <= 1'b0;
    while (averages_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all four registers while the block is idle.
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                             input logic [CFG_DATA_W-1:0] rw, input logic [CFG_DATA_W-1:0] rh);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_IDX_W-1:0]  idxs [4];
    vals = '{fw, fh, rw, rh};
    idxs = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_REGION_WIDTH, REG_REGION_HEIGHT};
    wait_until_settled();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      case (idxs[i])
        REG_FRAME_WIDTH:   frame_w_reg  = vals[i][FRAME_CFG_W-1:0];
        REG_FRAME_HEIGHT:  frame_h_reg  = vals[i][FRAME_CFG_W-1:0];
        REG_REGION_WIDTH:  region_w_reg = vals[i][REGION_CFG_W-1:0];
        REG_REGION_HEIGHT: region_h_reg = vals[i][REGION_CFG_W-1:0];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input bit tx, input bit rx);
    tx_idle_en <= tx;
    rx_idle_en <= rx;
  endtask

  // Reset values: an 8 by 8 region straddling the corner of a 640 by 480 frame.
  task automatic test_reset_defaults();
    send_region(12'd636, 12'd476, 1'b0);
  endtask

  // Single-pixel regions at the extremes of every field.
  task automatic test_field_extremes();
    bit closed;
    reconfigure(13'd4096, 13'd4096, 13'd1, 13'd1);
    send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, closed);
    send_pixel(12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255, closed);
    send_pixel(12'd0, 12'd0, 8'd255, 8'd0, 8'd0, closed);
    send_pixel(12'd0, 12'd0, 8'd0, 8'd255, 8'd0, closed);
    send_pixel(12'd0, 12'd0, 8'd0, 8'd0, 8'd255, closed);
    send_pixel(12'd4095, 12'd0, 8'd1, 8'd1, 8'd0, closed);
    send_pixel(12'd0, 12'd4095, 8'd2, 8'd0, 8'd0, closed);
  endtask

  // Regions outside the frame or cut by its edge, and frames of width or height zero.
  task automatic test_empty_regions();
    bit closed;
    reconfigure(13'd100, 13'd100, 13'd2, 13'd2);
    send_region(12'd200, 12'd50, 1'b0);
    send_region(12'd98, 12'd98, 1'b0);
    send_region(12'd99, 12'd99, 1'b0);
    reconfigure(13'd0, 13'd4096, 13'd2, 13'd2);
    send_region(12'd0, 12'd0, 1'b0);
    reconfigure(13'd4096, 13'd0, 13'd1, 13'd1);
    send_pixel(12'd0, 12'd0, 8'd200, 8'd100, 8'd50, closed);
  endtask

  // Sizes of zero act as one; oversized values are limited; upper data bits are dropped.
  task automatic test_size_limits();
    bit closed;
    reconfigure(13'h1FFF, 13'h1FFF, 13'd0, 13'd0);
    send_pixel(12'd4095, 12'd4095, 8'd10, 8'd20, 8'd30, closed);
    send_pixel(12'd4095, 12'd0, 8'd255, 8'd255, 8'd254, closed);
    reconfigure(13'd4096, 13'd4096, 13'h1FFF, 13'h0F81);
    send_region(12'd4040, 12'd7, 1'b0);
    reconfigure(13'd1, 13'd1, 13'h0080, 13'd127);
    send_region(12'd0, 12'd0, 1'b0);
  endtask

  // Region size shrunk while a region is half done.
  task automatic test_resize_mid_region();
    reconfigure(13'd4096, 13'd4096, 13'd4, 13'd4);
    send_partial(12'd10, 12'd10, 6);
    reconfigure(13'd4096, 13'd4096, 13'd2, 13'd4);
    send_partial(12'd10, 12'd10, 3);
    reconfigure(13'd4096, 13'd4096, 13'd2, 13'd2);
    send_region(12'd10, 12'd10, 1'b0);
    send_region(12'd4094, 12'd4094, 1'b0);
  endtask

  // Widest region in full white inside the frame, then the tallest one cut by
  // both frame edges.
  task automatic test_largest_region();
    bit closed;
    reconfigure(13'd4096, 13'd4096, 13'd64, 13'd4);
    closed = 1'b0;
    while (!closed) send_pixel(12'd0, 12'd0, 8'd255, 8'd255, 8'd255, closed);
    reconfigure(13'd4096, 13'd4096, 13'd4, 13'd64);
    send_region(12'd4093, 12'd4060, 1'b0);
  endtask

  // Receiver holds off for a long stretch while pixels keep coming.
  task automatic test_back_pressure();
    reconfigure(13'd4096, 13'd4096, 13'd1, 13'd1);
    set_idling(1'b0, 1'b0);
    hold_req_id <= hold_req_id + 1;
    send_partial(12'd5, 12'd5, 48);
    wait_until_settled();
  endtask

  // Random phases of well-formed regions with random settings, some noise and
  // some regions left half done across a reconfiguration.
  task automatic test_random_regions();
    logic [CFG_DATA_W-1:0] fw;
    logic [CFG_DATA_W-1:0] fh;
    logic [CFG_DATA_W-1:0] rw;
    logic [CFG_DATA_W-1:0] rh;
    int unsigned           cols;
    int unsigned           rows;
    int unsigned           first_pixel;
    int unsigned           region_total;
    first_pixel = pixels_sent;
    while (pixels_sent - first_pixel < RANDOM_PIXELS) begin
      fw = pick_frame_size();
      fh = pick_frame_size();
      rw = pick_region_size();
      rh = pick_region_size();
      cols = bounded(rw[REGION_CFG_W-1:0], 1, MAX_REGION_DEFAULT);
      rows = bounded(rh[REGION_CFG_W-1:0], 1, MAX_REGION_DEFAULT);
      if (cols * rows > 64) begin
        rh = 13'd1;
        rows = 1;
      end
      reconfigure(fw, fh, rw, rh);
      set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      region_total = $urandom_range(1, 10);
      for (int k = 0; k < region_total && pixels_sent - first_pixel < RANDOM_PIXELS; k++) begin
        send_region(pick_origin(fw, cols), pick_origin(fh, rows), $urandom_range(0, 7) == 0);
      end
      if ($urandom_range(0, 3) == 0) begin
        send_partial(pick_origin(fw, cols), pick_origin(fh, rows),
                     $urandom_range(1, cols * rows));
      end
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate_tail();
    set_idling(1'b0, 1'b0);
    reconfigure(13'd4096, 13'd4096, CFG_DATA_W'($urandom_range(1, 3)),
                CFG_DATA_W'($urandom_range(1, 3)));
    repeat (40) send_region(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
  endtask

  // Receiver: random stall bursts, or one long hold on request.
  initial begin
    int unsigned hold_ack;
    hold_ack = 0;
    forever begin
      @(posedge clk);
      if (hold_req_id != hold_ack) begin
        hold_ack = hold_req_id;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Each result beat against the oldest predicted average.
  always @(posedge clk) begin : check_result
    region_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (averages_due.size() == 0) begin
        note_failure($sformatf("result with none pending: average=%0d empty=%0b",
                               average, empty_res));
      end else begin
        due = averages_due.pop_front();
        if (due.average !== average || due.empty_res !== empty_res) begin
          note_failure($sformatf("average exp %0d got %0d, empty exp %0b got %0b",
                                 due.average, average, due.empty_res, empty_res));
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_field_extremes();
    test_empty_regions();
    test_size_limits();
    test_resize_mid_region();
    test_largest_region();
    test_back_pressure();
    test_random_regions();
    test_full_rate_tail();
    wait_until_settled();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (averages_due.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", averages_due.size()));
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
